FILE: sv/psenum_pkg.sv
`timescale 1ns / 1ps
// Shared types for the pair-sum enumerator.
// No dependencies; imported by the cell and the top level.
package psenum_pkg;

   // Per-cycle command broadcast to every cell of the chain.
   typedef struct packed {
      logic load;    // sorted insert of the incoming word
      logic pop;     // shift toward the head, head drops out
      logic rotate;  // shift toward the head, head wraps to the tail
   } cell_ctl_type;

endpackage

FILE: sv/psenum_req_if.sv
`timescale 1ns / 1ps
// Input channel: one element word per handshake.
// No dependencies.
interface psenum_req_if #(
   parameter int ELEM_WIDTH = 16
);
   logic                  valid;
   logic                  ready;
   logic [ELEM_WIDTH-1:0] element_value;
   logic                  is_last;

   modport source (output valid, output element_value, output is_last, input ready);
   modport sink   (input valid, input element_value, input is_last, output ready);
endinterface

FILE: sv/psenum_rsp_if.sv
`timescale 1ns / 1ps
// Result channel: one reported pair per handshake.
// No dependencies.
interface psenum_rsp_if #(
   parameter int ELEM_WIDTH = 16
);
   logic                  valid;
   logic                  ready;
   logic [ELEM_WIDTH-1:0] pair_low;
   logic [ELEM_WIDTH-1:0] pair_high;
   logic                  found;
   logic                  dropped;
   logic                  last_pair;

   modport source (output valid, output pair_low, output pair_high, output found,
                   output dropped, output last_pair, input ready);
   modport sink   (input valid, input pair_low, input pair_high, input found,
                   input dropped, input last_pair, output ready);
endinterface

FILE: sv/pair_sum_enumerate.sv
`timescale 1ns / 1ps
// Pair-sum enumerator. Element words are taken one per cycle and insertion-sorted
// on arrival in a chain of MAX_ELEMS cells. The last word starts a walk that pops
// the chain head in turn as a pair's low side and rotates the remaining elements
// once past it; result words leave during the walk, and a stalled result port
// stalls the walk. No word is taken while the walk runs.
// Reset (synchronous): store empty, overflow flag clear, target_sum = 0.
module pair_sum_enumerate
   import psenum_pkg::*;
#(
   parameter int MAX_ELEMS  = 8,
   parameter int ELEM_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   psenum_req_if.sink            req_chan,
   psenum_rsp_if.source          rsp_chan,
   input  logic                  csr_we,
   input  logic [ELEM_WIDTH:0]   csr_wdata
);

   localparam int SUM_W = ELEM_WIDTH + 1;
   localparam int CW    = $clog2(MAX_ELEMS + 1);

   typedef enum logic [1:0] {
      S_LOAD,   // collecting words
      S_POP,    // take chain head as the pair's low side
      S_SCAN,   // rotate remaining elements past the held low side
      S_FLUSH   // emit the held (final) result or the no-match word
   } state_type;

   // Control and payload registers
   state_type             state_ff,     state_in;
   logic [CW-1:0]         cnt_ff,       cnt_in;
   logic [CW-1:0]         rem_ff,       rem_in;
   logic                  ovf_ff,       ovf_in;
   logic                  drop_ff,      drop_in;
   logic [SUM_W-1:0]      tgt_ff,       tgt_in;
   logic [ELEM_WIDTH-1:0] a_ff,         a_in;
   logic                  pend_vld_ff,  pend_vld_in;
   logic [ELEM_WIDTH-1:0] pend_lo_ff,   pend_lo_in;
   logic [ELEM_WIDTH-1:0] pend_hi_ff,   pend_hi_in;
   logic                  rsp_vld_ff,   rsp_vld_in;
   logic [ELEM_WIDTH-1:0] rsp_lo_ff,    rsp_lo_in;
   logic [ELEM_WIDTH-1:0] rsp_hi_ff,    rsp_hi_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic                  rsp_drop_ff,  rsp_drop_in;
   logic                  rsp_last_ff,  rsp_last_in;

   cell_ctl_type          ctl;
   logic [ELEM_WIDTH-1:0] cell_val [MAX_ELEMS];
   logic [MAX_ELEMS-1:0]  cell_gt;
   logic [ELEM_WIDTH-1:0] head;
   logic [SUM_W-1:0]      pair_sum;
   logic                  match;
   logic                  out_free;
   logic                  req_fire;
   logic                  full;

   assign head     = cell_val[0];
   assign pair_sum = {a_ff[ELEM_WIDTH-1], a_ff} + {head[ELEM_WIDTH-1], head};
   assign match    = (pair_sum == tgt_ff);
   assign out_free = !rsp_vld_ff || rsp_chan.ready;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign full     = (cnt_ff == CW'(MAX_ELEMS));

   assign req_chan.ready     = (state_ff == S_LOAD);
   assign rsp_chan.valid     = rsp_vld_ff;
   assign rsp_chan.pair_low  = rsp_lo_ff;
   assign rsp_chan.pair_high = rsp_hi_ff;
   assign rsp_chan.found     = rsp_found_ff;
   assign rsp_chan.dropped   = rsp_drop_ff;
   assign rsp_chan.last_pair = rsp_last_ff;

   // Chain of cells. Cell 0 is the head; values stay sorted ascending from it.
   for (genvar k = 0; k < MAX_ELEMS; k++) begin : g_cell
      logic [ELEM_WIDTH-1:0] left_v;
      logic                  left_g;
      logic [ELEM_WIDTH-1:0] right_v;

      if (k == 0) begin : g_first
         assign left_v = req_chan.element_value;
         assign left_g = 1'b0;
      end else begin : g_mid
         assign left_v = cell_val[k-1];
         assign left_g = cell_gt[k-1];
      end
      if (k == MAX_ELEMS - 1) begin : g_end
         assign right_v = cell_val[k];
      end else begin : g_inner
         assign right_v = cell_val[k+1];
      end

      psenum_cell #(
         .ELEM_WIDTH (ELEM_WIDTH)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (cnt_ff > CW'(k)),
         .is_tail     (cnt_ff == CW'(k + 1)),
         .ins_value   (req_chan.element_value),
         .left_value  (left_v),
         .left_gt     (left_g),
         .right_value (right_v),
         .head_value  (head),
         .value       (cell_val[k]),
         .gt          (cell_gt[k])
      );
   end

   // Matches are held back one step so the final one can carry last_pair.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      ovf_in       = ovf_ff;
      drop_in      = drop_ff;
      tgt_in       = csr_we ? csr_wdata : tgt_ff;
      a_in         = a_ff;
      pend_vld_in  = pend_vld_ff;
      pend_lo_in   = pend_lo_ff;
      pend_hi_in   = pend_hi_ff;
      rsp_vld_in   = rsp_chan.ready ? 1'b0 : rsp_vld_ff;
      rsp_lo_in    = rsp_lo_ff;
      rsp_hi_in    = rsp_hi_ff;
      rsp_found_in = rsp_found_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_last_in  = rsp_last_ff;
      ctl          = '0;

      unique case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               if (!full) begin
                  ctl.load = 1'b1;
                  cnt_in   = cnt_ff + CW'(1);
               end
               if (req_chan.is_last) begin
                  drop_in     = ovf_ff || full;
                  ovf_in      = 1'b0;
                  pend_vld_in = 1'b0;
                  state_in    = S_POP;
               end else begin
                  ovf_in = ovf_ff || full;
               end
            end
         end
         S_POP: begin
            if (cnt_ff <= CW'(1)) begin
               state_in = S_FLUSH;
            end else begin
               ctl.pop  = 1'b1;
               a_in     = head;
               cnt_in   = cnt_ff - CW'(1);
               rem_in   = cnt_ff - CW'(1);
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!(match && pend_vld_ff && !out_free)) begin
               ctl.rotate = 1'b1;
               if (match) begin
                  if (pend_vld_ff) begin
                     rsp_vld_in   = 1'b1;
                     rsp_lo_in    = pend_lo_ff;
                     rsp_hi_in    = pend_hi_ff;
                     rsp_found_in = 1'b1;
                     rsp_drop_in  = drop_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_vld_in = 1'b1;
                  pend_lo_in  = a_ff;   // chain is sorted, so a_ff <= head
                  pend_hi_in  = head;
               end
               rem_in = rem_ff - CW'(1);
               if (rem_ff == CW'(1)) begin
                  state_in = S_POP;
               end
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               rsp_vld_in   = 1'b1;
               rsp_lo_in    = pend_vld_ff ? pend_lo_ff : '0;
               rsp_hi_in    = pend_vld_ff ? pend_hi_ff : '0;
               rsp_found_in = pend_vld_ff;
               rsp_drop_in  = drop_ff;
               rsp_last_in  = 1'b1;
               pend_vld_in  = 1'b0;
               cnt_in       = '0;
               state_in     = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_LOAD;
         cnt_ff      <= '0;
         rem_ff      <= '0;
         ovf_ff      <= 1'b0;
         drop_ff     <= 1'b0;
         tgt_ff      <= '0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         rem_ff      <= rem_in;
         ovf_ff      <= ovf_in;
         drop_ff     <= drop_in;
         tgt_ff      <= tgt_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      a_ff         <= a_in;
      pend_lo_ff   <= pend_lo_in;
      pend_hi_ff   <= pend_hi_in;
      rsp_lo_ff    <= rsp_lo_in;
      rsp_hi_ff    <= rsp_hi_in;
      rsp_found_ff <= rsp_found_in;
      rsp_drop_ff  <= rsp_drop_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

FILE: sv/psenum_cell.sv
`timescale 1ns / 1ps
// One cell of the sorted element chain: holds one element.
// Depends on psenum_pkg.
module psenum_cell
   import psenum_pkg::*;
#(
   parameter int ELEM_WIDTH = 16
) (
   input  logic                  clock,
   input  cell_ctl_type          ctl,
   input  logic                  occupied,
   input  logic                  is_tail,
   input  logic [ELEM_WIDTH-1:0] ins_value,
   input  logic [ELEM_WIDTH-1:0] left_value,
   input  logic                  left_gt,
   input  logic [ELEM_WIDTH-1:0] right_value,
   input  logic [ELEM_WIDTH-1:0] head_value,
   output logic [ELEM_WIDTH-1:0] value,
   output logic                  gt
);

   logic [ELEM_WIDTH-1:0] value_ff;
   logic [ELEM_WIDTH-1:0] value_in;

   // Empty cells count as greater so the new word lands at the end of the run.
   assign gt    = !occupied || ($signed(value_ff) > $signed(ins_value));
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctl.load) begin
         if (gt) begin
            value_in = left_gt ? left_value : ins_value;
         end
      end else if (ctl.pop) begin
         value_in = right_value;
      end else if (ctl.rotate) begin
         value_in = is_tail ? head_value : right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for pair_sum_enumerate: drives element words, predicts the
// reported pairs with its own model and checks every result word field by field.
// Depends on the RTL: psenum_pkg, psenum_req_if, psenum_rsp_if and pair_sum_enumerate.
module tb_top;

   localparam int MAX_ELEMS      = 8;
   localparam int ELEM_WIDTH     = 16;
   localparam int MAX_PAIRS      = MAX_ELEMS * (MAX_ELEMS - 1) / 2;
   localparam int MAX_GAP        = 11;    // longest sender gap / receiver stall
   localparam int SETTLE_CYCLES  = 64;    // outlasts a full walk
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moved on either side
   localparam int RANDOM_WORDS   = 370;   // random budget; directed sets add 25 words
   localparam int PHASES         = 6;
   localparam int ELEM_MAX       = 32767;
   localparam int ELEM_MIN       = -32768;

   // one element word waiting to be sent
   typedef struct {
      logic [ELEM_WIDTH-1:0] value;
      logic                  last;
   } elem_word_type;

   // one result word as the block should report it
   typedef struct {
      logic [ELEM_WIDTH-1:0] low;
      logic [ELEM_WIDTH-1:0] high;
      logic                  found;
      logic                  dropped;
      logic                  last_pair;
   } pair_word_type;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [ELEM_WIDTH:0] csr_wdata;

   psenum_req_if #(.ELEM_WIDTH(ELEM_WIDTH)) req_if ();
   psenum_rsp_if #(.ELEM_WIDTH(ELEM_WIDTH)) rsp_if ();

   pair_sum_enumerate #(
      .MAX_ELEMS  (MAX_ELEMS),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // words queued by the stimulus block, consumed by the driver
   elem_word_type pending_words[$];
   // pairs predicted from accepted words, consumed by the monitor
   pair_word_type expected_pairs[$];

   // predictor state: its own copy of the store and of target_sum
   logic signed [ELEM_WIDTH-1:0] model_elems[MAX_ELEMS];
   int                           model_count    = 0;
   logic                         model_overflow = 1'b0;
   logic signed [ELEM_WIDTH:0]   model_target   = '0;

   int mismatches   = 0;
   int words_sent   = 0;
   int sets_closed  = 0;
   int results_seen = 0;
   int cfg_writes   = 0;

   // sender / receiver pacing; "calm" stretches run with no idling at all
   bit tx_calm    = 1'b0;
   bit rx_calm    = 1'b0;
   int gap_left   = 0;
   int stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Predictor. Stores the word (or flags the overflow when the store is full); on a
   // last word it lists every i<j pair that hits the target, low value first, sorted
   // by (low, high) with duplicates kept, then empties the store.
   function automatic void enumerate_pairs(input logic [ELEM_WIDTH-1:0] value,
                                           input logic last);
      int            lows[MAX_PAIRS];
      int            highs[MAX_PAIRS];
      int            n;
      int            i;
      int            j;
      int            k;
      int            a;
      int            b;
      int            lo;
      int            hi;
      int            tgt;
      pair_word_type pw;
      n = 0;
      if (model_count < MAX_ELEMS) begin
         model_elems[model_count] = value;
         model_count++;
      end else begin
         model_overflow = 1'b1;
      end
      if (!last) return;

      sets_closed++;
      tgt = model_target;
      for (i = 0; i < model_count; i++) begin
         for (j = i + 1; j < model_count; j++) begin
            a = model_elems[i];
            b = model_elems[j];
            if (a + b == tgt) begin
               lo = (a < b) ? a : b;
               hi = (a < b) ? b : a;
               // insertion keeps the list ordered by low, then high
               k = n;
               while (k > 0 && (lows[k-1] > lo || (lows[k-1] == lo && highs[k-1] > hi))) begin
                  lows[k]  = lows[k-1];
                  highs[k] = highs[k-1];
                  k--;
               end
               lows[k]  = lo;
               highs[k] = hi;
               n++;
            end
         end
      end

      if (n == 0) begin
         // no match (also every set of fewer than two elements)
         pw.low       = '0;
         pw.high      = '0;
         pw.found     = 1'b0;
         pw.dropped   = model_overflow;
         pw.last_pair = 1'b1;
         expected_pairs = {expected_pairs, pw};
      end else begin
         for (k = 0; k < n; k++) begin
            pw.low       = lows[k][ELEM_WIDTH-1:0];
            pw.high      = highs[k][ELEM_WIDTH-1:0];
            pw.found     = 1'b1;
            pw.dropped   = model_overflow;
            pw.last_pair = (k == n - 1);
            expected_pairs = {expected_pairs, pw};
         end
      end
      model_count    = 0;
      model_overflow = 1'b0;
   endfunction

   function automatic int report_field(input string name, input logic signed [ELEM_WIDTH:0] want,
                                       input logic signed [ELEM_WIDTH:0] got);
      if (got === want) return 0;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1;
   endfunction

   // Driver: presents the next pending word after its drawn gap; the prediction
   // is made at the edge where the word is accepted.
   always @(posedge clock) begin : drive_req
      logic          busy;
      elem_word_type next_word;
      if (reset) begin
         req_if.valid         <= 1'b0;
         req_if.element_value <= '0;
         req_if.is_last       <= 1'b0;
         gap_left = 0;
      end else begin
         busy = req_if.valid;
         if (req_if.valid && req_if.ready) begin
            enumerate_pairs(req_if.element_value, req_if.is_last);
            words_sent++;
            busy = 1'b0;
            if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
            gap_left = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
         end
         // at most one assignment to valid per edge
         if (!busy) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               next_word = pending_words.pop_front();
               req_if.valid         <= 1'b1;
               req_if.element_value <= next_word.value;
               req_if.is_last       <= next_word.last;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted result word against the oldest prediction,
   // then draws how long ready stays low before the next word.
   always @(posedge clock) begin : watch_rsp
      pair_word_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (expected_pairs.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual low %0d high %0d %s",
                        $time, $signed(rsp_if.pair_low), $signed(rsp_if.pair_high),
                        $sformatf("found %0b dropped %0b last %0b", rsp_if.found,
                                  rsp_if.dropped, rsp_if.last_pair));
               mismatches++;
            end else begin
               want = expected_pairs.pop_front();
               mismatches += report_field("pair_low", $signed(want.low),
                                          $signed(rsp_if.pair_low));
               mismatches += report_field("pair_high", $signed(want.high),
                                          $signed(rsp_if.pair_high));
               mismatches += report_field("found", want.found, rsp_if.found);
               mismatches += report_field("dropped", want.dropped, rsp_if.dropped);
               mismatches += report_field("last_pair", want.last_pair, rsp_if.last_pair);
            end
            if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
            stall_left = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_if.ready <= (stall_left == 0);
      end
   end

   // Watchdog: a correct run never goes this long without moving a word.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
         else quiet++;
      end
      $display("%0t ns: watchdog expired, %0d words pending, %0d results outstanding",
               $time, pending_words.size(), expected_pairs.size());
      $display("Mismatches found");
      $finish;
   end

   task automatic push_word(input int value, input logic last);
      elem_word_type w;
      w.value = value[ELEM_WIDTH-1:0];
      w.last  = last;
      pending_words = {pending_words, w};
   endtask

   // Sender holds off until every queued word is taken and every predicted result
   // has come back, then lets a walk's worth of cycles pass so the block is idle.
   // Sampled on the falling edge, clear of the driver's updates.
   task automatic drain_phase();
      @(negedge clock);
      while (pending_words.size() != 0 || req_if.valid || expected_pairs.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // target_sum write; only called with the block idle
   task automatic write_target(input int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value[ELEM_WIDTH:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      model_target = value[ELEM_WIDTH:0];
      cfg_writes++;
      @(negedge clock);
   endtask

   initial begin : stimulus
      int                         phase;
      int                         phase_words;
      int                         set_len;
      int                         i;
      int                         r;
      int                         v;
      int                         c;
      int                         tgt;
      bit                         open_set;
      logic signed [ELEM_WIDTH:0] t17;
      int                         set_vals[$];

      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_wdata            = '0;
      req_if.valid         = 1'b0;
      req_if.element_value = '0;
      req_if.is_last       = 1'b0;
      rsp_if.ready         = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed part, target at its reset value 0 ---
      // duplicates and the low/high tie order: four (-5,5) then (0,0)
      push_word(5, 1'b0);
      push_word(-5, 1'b0);
      push_word(0, 1'b0);
      push_word(0, 1'b0);
      push_word(-5, 1'b0);
      push_word(5, 1'b1);
      // single element: no pair possible
      push_word(7, 1'b1);
      // overflow: ten words, the last two are dropped but emission still runs
      push_word(ELEM_MIN, 1'b0);
      push_word(ELEM_MAX, 1'b0);
      push_word(1, 1'b0);
      push_word(-1, 1'b0);
      push_word(100, 1'b0);
      push_word(-100, 1'b0);
      push_word(21845, 1'b0);
      push_word(-21845, 1'b0);
      push_word(3, 1'b0);
      push_word(-3, 1'b1);
      // plain no-match set
      push_word(1, 1'b0);
      push_word(2, 1'b1);
      drain_phase();

      // most negative target, reached only by two minimum elements
      write_target(-65536);
      push_word(ELEM_MIN, 1'b0);
      push_word(ELEM_MIN, 1'b1);
      drain_phase();
      // largest reachable target
      write_target(65534);
      push_word(ELEM_MAX, 1'b0);
      push_word(ELEM_MAX, 1'b1);
      drain_phase();
      // register maximum: no sum can reach it
      write_target(65535);
      push_word(ELEM_MAX, 1'b0);
      push_word(ELEM_MAX, 1'b1);
      drain_phase();

      // --- random part: one target per phase, sets built to hit it ---
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       t17 = 17'($urandom_range(0, 131071));
            1:       t17 = 17'(int'($urandom_range(0, 40)) - 20);
            2:       t17 = '0;
            3:       t17 = 17'(-65536 + int'($urandom_range(0, 200)));
            4:       t17 = 17'(65534 - int'($urandom_range(0, 200)));
            default: t17 = 17'(int'($urandom_range(0, 2000)) - 1000);
         endcase
         write_target(t17);
         tgt = t17;

         phase_words = 0;
         set_vals.delete();
         while (phase_words < RANDOM_WORDS / PHASES) begin
            r = $urandom_range(0, 99);
            if (r < 78) set_len = $urandom_range(2, MAX_ELEMS);
            else if (r < 90) set_len = $urandom_range(MAX_ELEMS + 1, MAX_ELEMS + 4);
            else set_len = 1;
            // now and then a set is left open and runs into the next one;
            // the last set of a phase is always closed
            open_set = ($urandom_range(0, 19) == 0) &&
                       (phase_words + set_len < RANDOM_WORDS / PHASES);
            for (i = 0; i < set_len; i++) begin
               r = $urandom_range(0, 99);
               c = ELEM_MAX + 1;
               if (r < 45 && set_vals.size() > 0)
                  c = tgt - set_vals[$urandom_range(0, set_vals.size() - 1)];
               if (c >= ELEM_MIN && c <= ELEM_MAX) begin
                  v = c;  // complement of an element already in the set
               end else if (r < 75) begin
                  v = tgt / 2 + int'($urandom_range(0, 16)) - 8;
               end else if (r < 90) begin
                  v = $signed(16'($urandom_range(0, 65535)));
               end else begin
                  case ($urandom_range(0, 3))
                     0:       v = ELEM_MIN;
                     1:       v = ELEM_MAX;
                     2:       v = 0;
                     default: v = -1;
                  endcase
               end
               if (v > ELEM_MAX) v = ELEM_MAX;
               if (v < ELEM_MIN) v = ELEM_MIN;
               set_vals = {set_vals, v};
               push_word(v, (i == set_len - 1) && !open_set);
            end
            if (!open_set) set_vals.delete();
            phase_words += set_len;
         end
         // full drain before the next target write
         drain_phase();
      end

      $display("Sent %0d element words closing %0d sets; checked %0d result words",
               words_sent, sets_closed, results_seen);
      $display("over %0d target_sum settings incl. both range ends and an unreachable one",
               cfg_writes + 1);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: pair_sum_enumerate.f
sv/psenum_pkg.sv
sv/psenum_req_if.sv
sv/psenum_rsp_if.sv
sv/psenum_cell.sv
sv/pair_sum_enumerate.sv
tb/tb_top.sv
